FILE: hdl/pbmd_pkg.sv
`timescale 1ns / 1ps
package pbmd_pkg;

  localparam int WINDOW_DEF = 100;

  localparam int SAMPLE_W   = 14;
  localparam int THRESH_W   = 23;
  localparam int MINC_W     = 7;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int FILT_W     = 24;
  localparam int XH_W       = 29;
  localparam int YH_W       = 40;
  localparam int ACC_W      = 64;
  localparam int COEF_W     = 24;
  localparam int NUM_TAPS   = 6;
  localparam int HIST_DEPTH = 7;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd896;
  localparam logic [MINC_W-1:0]   MINC_RESET   = 7'd3;

  // 1/GAIN in Q0.32
  localparam logic [30:0] INV_GAIN_Q32 = 31'd1442930688;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD,
    REG_MIN_COUNT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAC_NONE,
    MAC_LO,
    MAC_HI,
    MAC_ACC
  } mac_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XCONV,
    ST_XSUM,
    ST_MAC_LO,
    ST_MAC_HI,
    ST_MAC_ACC,
    ST_YOUT,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       xconv;
    logic       xsum;
    mac_op_t    mac;
    logic [2:0] coef_idx;
    logic       yout;
    logic       wr;
    logic       scan_rd;
    logic       decide;
    logic       out_load;
  } pbmd_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } pbmd_stat_t;

  // Feedback coefficients in Q2.22, oldest output first
  function automatic logic signed [COEF_W-1:0] coef_q22(input logic [2:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      3'd0:    c = 24'sd456952;
      3'd1:    c = 24'sd927066;
      3'd2:    c = -24'sd2121709;
      3'd3:    c = -24'sd1535388;
      3'd4:    c = -24'sd561240;
      3'd5:    c = 24'sd7018451;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/pbmd_ram.sv
`timescale 1ns / 1ps
module pbmd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pbmd_ctrl.sv
`timescale 1ns / 1ps
module pbmd_ctrl import pbmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  pbmd_stat_t stat,
  output pbmd_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic [2:0]  coef_idx;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      coef_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == ST_XSUM) begin
        coef_idx <= '0;
      end else if (state == ST_MAC_ACC) begin
        coef_idx <= coef_idx + 3'd1;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mac      = MAC_NONE;
    cmd.coef_idx = coef_idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_XCONV;
        end
      end
      ST_XCONV: begin
        cmd.xconv  = 1'b1;
        state_next = ST_XSUM;
      end
      ST_XSUM: begin
        cmd.xsum   = 1'b1;
        state_next = ST_MAC_LO;
      end
      ST_MAC_LO: begin
        cmd.mac    = MAC_LO;
        state_next = ST_MAC_HI;
      end
      ST_MAC_HI: begin
        cmd.mac    = MAC_HI;
        state_next = ST_MAC_ACC;
      end
      ST_MAC_ACC: begin
        cmd.mac    = MAC_ACC;
        state_next = (coef_idx == 3'(NUM_TAPS - 1)) ? ST_YOUT : ST_MAC_LO;
      end
      ST_YOUT: begin
        cmd.yout   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = stat.need_scan ? ST_SCAN : ST_OUT;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

FILE: hdl/pbmd_dp.sv
`timescale 1ns / 1ps
module pbmd_dp import pbmd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [SAMPLE_W-1:0]      raw_sample,
  input  pbmd_cmd_t                cmd,
  output pbmd_stat_t               stat,
  output logic signed [FILT_W-1:0] filtered,
  output logic                     decided,
  output logic                     motion
);

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int CMPW = (CW > MINC_W) ? CW : MINC_W;

  logic [THRESH_W-1:0] threshold;
  logic [MINC_W-1:0]   min_count;

  logic [SAMPLE_W-1:0]    raw_q;
  logic [XH_W-1:0]        xh [0:HIST_DEPTH-1];
  logic signed [YH_W-1:0] yh [0:HIST_DEPTH-1];

  logic [44:0]             xprod;
  logic [44:0]             xprod_rnd;
  logic [XH_W-1:0]         xconv_val;
  logic signed [32:0]      xdiff;
  logic signed [32:0]      xs;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod;
  logic signed [COEF_W-1:0] coef_cur;
  logic signed [YH_W-1:0]   ysel;
  logic signed [20:0]       mop;
  logic signed [44:0]       mul;
  logic signed [ACC_W-1:0]  mul_ext;

  logic signed [ACC_W-1:0]  yt;
  logic signed [YH_W-1:0]   ynew;
  logic signed [YH_W:0]     yr;
  logic signed [YH_W-8:0]   fu;
  logic signed [FILT_W-1:0] filt_val;
  logic signed [FILT_W-1:0] filt_r;

  logic [AW-1:0]          wr_pos;
  logic [AW-1:0]          fill_rem;
  logic [AW-1:0]          rd_addr;
  logic                   rd_valid;
  logic [FILT_W-1:0]      rdata;
  logic [CW-1:0]          pos_cnt;
  logic [CW-1:0]          neg_cnt;
  logic signed [FILT_W:0] entry;
  logic signed [FILT_W:0] lim_pos;
  logic signed [FILT_W:0] lim_neg;
  logic                   motion_val;
  logic                   res_decided;
  logic                   res_motion;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      min_count <= MINC_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        REG_MIN_COUNT: min_count <= cfg_data[MINC_W-1:0];
        default: ;
      endcase
    end
  end

  // scale by 1/GAIN, round to Q.16
  assign xprod     = {31'd0, raw_q} * {14'd0, INV_GAIN_Q32};
  assign xprod_rnd = xprod + 45'd32768;
  assign xconv_val = xprod_rnd[44:16];

  assign xdiff = $signed({4'd0, xh[2]}) - $signed({4'd0, xh[4]});
  assign xs    = $signed({4'd0, xh[6]}) - $signed({4'd0, xh[0]}) + xdiff + (xdiff <<< 1);

  // feedback products in two halves of y
  assign coef_cur = coef_q22(cmd.coef_idx);
  assign ysel     = yh[cmd.coef_idx];
  assign mop      = (cmd.mac == MAC_LO) ? $signed({1'b0, ysel[19:0]})
                                        : $signed({ysel[YH_W-1], ysel[YH_W-1:20]});
  assign mul      = coef_cur * mop;
  assign mul_ext  = {{(ACC_W-45){mul[44]}}, mul};

  // round to Q.16, saturate to 40 bits
  assign yt = (acc + 64'sd32768) >>> 16;
  always_comb begin
    if ((&yt[ACC_W-1:YH_W-1]) || !(|yt[ACC_W-1:YH_W-1])) begin
      ynew = yt[YH_W-1:0];
    end else if (yt[ACC_W-1]) begin
      ynew = {1'b1, {(YH_W-1){1'b0}}};
    end else begin
      ynew = {1'b0, {(YH_W-1){1'b1}}};
    end
  end

  // round to Q.8, saturate to 24 bits
  assign yr = {yh[HIST_DEPTH-1][YH_W-1], yh[HIST_DEPTH-1]} + 41'sd128;
  assign fu = yr[YH_W:8];
  always_comb begin
    if ((&fu[YH_W-8:FILT_W-1]) || !(|fu[YH_W-8:FILT_W-1])) begin
      filt_val = fu[FILT_W-1:0];
    end else if (fu[YH_W-8]) begin
      filt_val = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      filt_val = {1'b0, {(FILT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_q <= raw_sample;
    end
    if (cmd.xsum) begin
      acc <= {{(ACC_W-33){xs[32]}}, xs} <<< 16;
    end else if (cmd.mac == MAC_ACC) begin
      acc <= acc + (prod >>> 6);
    end
    if (cmd.mac == MAC_LO) begin
      prod <= mul_ext;
    end else if (cmd.mac == MAC_HI) begin
      prod <= prod + (mul_ext <<< 20);
    end
    if (cmd.wr) begin
      filt_r <= filt_val;
    end
  end

  // filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else if (cmd.xconv) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        xh[i] <= xh[i+1];
        yh[i] <= yh[i+1];
      end
      xh[HIST_DEPTH-1] <= xconv_val;
    end else if (cmd.yout) begin
      yh[HIST_DEPTH-1] <= ynew;
    end
  end

  pbmd_ram #(
    .WIDTH(FILT_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(wr_pos),
    .wdata(filt_val),
    .re   (cmd.scan_rd),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign entry   = $signed({rdata[FILT_W-1], rdata});
  assign lim_pos = $signed({2'b00, threshold});
  assign lim_neg = -lim_pos;

  assign motion_val = (CMPW'(pos_cnt) >= CMPW'(min_count)) &&
                      (CMPW'(neg_cnt) >= CMPW'(min_count));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos      <= '0;
      fill_rem    <= AW'(WINDOW - 1);
      rd_addr     <= '0;
      rd_valid    <= 1'b0;
      pos_cnt     <= '0;
      neg_cnt     <= '0;
      res_decided <= 1'b0;
      res_motion  <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.wr) begin
        wr_pos      <= (wr_pos == AW'(WINDOW - 1)) ? '0 : wr_pos + 1'b1;
        rd_addr     <= '0;
        pos_cnt     <= '0;
        neg_cnt     <= '0;
        res_decided <= 1'b0;
        res_motion  <= 1'b0;
        if (fill_rem != '0) begin
          fill_rem <= fill_rem - 1'b1;
        end
      end
      if (cmd.scan_rd) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (rd_valid) begin
        if (entry > lim_pos) begin
          pos_cnt <= pos_cnt + 1'b1;
        end
        if (entry < lim_neg) begin
          neg_cnt <= neg_cnt + 1'b1;
        end
      end
      if (cmd.decide) begin
        res_decided <= 1'b1;
        res_motion  <= motion_val;
        // detection: refill the ring from the start
        if (motion_val) begin
          wr_pos   <= '0;
          fill_rem <= AW'(WINDOW - 1);
        end
      end
    end
  end

  assign stat.need_scan = (fill_rem == '0);
  assign stat.scan_last = (rd_addr == AW'(WINDOW - 1));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered <= filt_r;
      decided  <= res_decided;
      motion   <= res_motion;
    end
  end

endmodule

FILE: hdl/pir_bandpass_motion_detector.sv
`timescale 1ns / 1ps
// PIR motion detector: sixth-order bandpass IIR on each 14-bit sample, then a
// bipolar excursion count over a ring of the last WINDOW filter outputs.
// Input channel: raw_sample with in_valid/in_stall; a transaction moves when
// in_valid is high and in_stall low. Output channel: filtered, decided,
// motion with out_valid/out_stall; exactly one result per input transaction.
// Config: cfg_we writes cfg_data to register cfg_index (0 threshold, 1
// min_count) at the clock edge; write only while no transaction is in flight.
// Sequence: each sample steps through history shift, input sum, the 6 taps
// (each a low-half, high-half and accumulate step on the one shared 24x21
// multiplier), rounding and the ring write; once decisions start, a scan
// then reads every ring entry through the single RAM read port before the
// decision. No new sample is taken until the previous result is loaded
// into the output register.
// The output register holds a finished result while the next sample is
// accepted and filtered; out_stall only holds the block when the following
// result is ready and the register is still full.
// Reset (rst, synchronous): clears filter history, restarts ring filling
// (WINDOW-1 samples undecided), threshold 896 (3.5 in Q.8), min_count 3.
module pir_bandpass_motion_detector import pbmd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_W-1:0]      raw_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [FILT_W-1:0] filtered,
  output logic                     decided,
  output logic                     motion
);

  pbmd_cmd_t  cmd;
  pbmd_stat_t stat;

  // sequencer: steps each sample through filter, ring write and, once the ring has filled, the scan
  pbmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, configuration, history, ring memory and the output register
  pbmd_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raw_sample(raw_sample),
    .cmd       (cmd),
    .stat      (stat),
    .filtered  (filtered),
    .decided   (decided),
    .motion    (motion)
  );

  // motion is only ever reported alongside a decision
  a_motion_needs_decision: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motion) |-> decided)
    else $error("motion flagged without a window decision");

  // an accepted sample holds the input side for its whole processing
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous sample still in progress");

  // no result can appear the cycle after a sample is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result produced without filter processing");

  // a new result is loaded only in the sequencer's output step, never alongside scan, write or multiply work
  a_load_from_output_step: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!cmd.scan_rd && !cmd.wr && (cmd.mac == MAC_NONE)))
    else $error("output load overlaps datapath work");

endmodule
